// ===== rtl/core/fut_pkg.sv =====
package fut_pkg;

  localparam int unsigned MaxResults = 5;
  localparam int unsigned CntWidth = $clog2(MaxResults + 1);
  localparam int unsigned IdxWidth = $clog2(MaxResults);
  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic [2:0] {
    KIND_NAME_BYTE  = 3'd0,
    KIND_VALUE_BYTE = 3'd1,
    KIND_NAME_END   = 3'd2,
    KIND_VALUE_END  = 3'd3,
    KIND_END_DATA   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic [CntWidth-1:0]        cnt;
    entry_t [MaxResults-1:0]    ent;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } head_t;

endpackage

// ===== rtl/core/fut_front.sv =====
module fut_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  input  logic            is_final_i,
  input  logic            space_i,
  output logic            in_ready_o,
  output logic            push_o,
  output fut_pkg::desc_t  push_desc_o
);

  localparam logic [7:0] ChEquals  = 8'h3D;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChPercent = 8'h25;

  logic       in_value_q, in_value_d;
  logic [1:0] esc_q, esc_d;
  logic [7:0] hex1_q, hex1_d;
  logic       seg_q, seg_d;
  logic       accept;
  logic       consumed;
  logic [4:0] hex_b, hex_h;
  fut_pkg::desc_t desc;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic fut_pkg::desc_t add(input fut_pkg::desc_t d, input fut_pkg::kind_e k,
                                         input logic [7:0] b);
    fut_pkg::desc_t r;
    r = d;
    r.ent[d.cnt[fut_pkg::IdxWidth-1:0]] = '{kind: k, data: b};
    r.cnt = d.cnt + 1'b1;
    return r;
  endfunction

  assign accept = in_valid_i && space_i;
  assign in_ready_o = space_i;
  assign hex_b = hex_digit(in_byte_i);
  assign hex_h = hex_digit(hex1_q);

  always_comb begin
    desc = '0;
    in_value_d = in_value_q;
    esc_d = esc_q;
    hex1_d = hex1_q;
    seg_d = seg_q;
    consumed = 1'b0;

    // Escape in progress: either take a hex digit or emit the pending bytes literally.
    if (esc_q != 2'd0) begin
      if (hex_b[4]) begin
        consumed = 1'b1;
        if (esc_q == 2'd1) begin
          hex1_d = in_byte_i;
          esc_d = 2'd2;
        end else begin
          desc = add(desc, in_value_q ? fut_pkg::KIND_VALUE_BYTE : fut_pkg::KIND_NAME_BYTE,
                     {hex_h[3:0], hex_b[3:0]});
          seg_d = 1'b1;
          esc_d = 2'd0;
          hex1_d = '0;
        end
      end else begin
        desc = add(desc, in_value_q ? fut_pkg::KIND_VALUE_BYTE : fut_pkg::KIND_NAME_BYTE,
                   ChPercent);
        if (esc_q == 2'd2) begin
          desc = add(desc, in_value_q ? fut_pkg::KIND_VALUE_BYTE : fut_pkg::KIND_NAME_BYTE,
                     hex1_q);
        end
        seg_d = 1'b1;
        esc_d = 2'd0;
        hex1_d = '0;
      end
    end

    if (!consumed) begin
      if (in_byte_i == ChPercent) begin
        esc_d = 2'd1;
        hex1_d = '0;
      end else if (in_byte_i == ChEquals && !in_value_d) begin
        desc = add(desc, fut_pkg::KIND_NAME_END, 8'h00);
        in_value_d = 1'b1;
        seg_d = 1'b1;
      end else if (in_byte_i == ChAmp) begin
        if (in_value_d) begin
          desc = add(desc, fut_pkg::KIND_VALUE_END, 8'h00);
        end else if (seg_d) begin
          desc = add(desc, fut_pkg::KIND_NAME_END, 8'h00);
          desc = add(desc, fut_pkg::KIND_VALUE_END, 8'h00);
        end
        in_value_d = 1'b0;
        seg_d = 1'b0;
      end else begin
        desc = add(desc, in_value_d ? fut_pkg::KIND_VALUE_BYTE : fut_pkg::KIND_NAME_BYTE,
                   in_byte_i);
        seg_d = 1'b1;
      end
    end

    if (is_final_i) begin
      if (esc_d != 2'd0) begin
        desc = add(desc, in_value_d ? fut_pkg::KIND_VALUE_BYTE : fut_pkg::KIND_NAME_BYTE,
                   ChPercent);
        seg_d = 1'b1;
      end
      if (esc_d == 2'd2) begin
        desc = add(desc, in_value_d ? fut_pkg::KIND_VALUE_BYTE : fut_pkg::KIND_NAME_BYTE,
                   hex1_d);
      end
      if (in_value_d) begin
        desc = add(desc, fut_pkg::KIND_VALUE_END, 8'h00);
      end else if (seg_d) begin
        desc = add(desc, fut_pkg::KIND_NAME_END, 8'h00);
      end
      desc = add(desc, fut_pkg::KIND_END_DATA, 8'h00);
      in_value_d = 1'b0;
      esc_d = 2'd0;
      hex1_d = '0;
      seg_d = 1'b0;
    end
  end

  assign push_o = accept && (desc.cnt != '0);
  assign push_desc_o = desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_value_q <= 1'b0;
      esc_q <= 2'd0;
      hex1_q <= '0;
      seg_q <= 1'b0;
    end else if (accept) begin
      in_value_q <= in_value_d;
      esc_q <= esc_d;
      hex1_q <= hex1_d;
      seg_q <= seg_d;
    end
  end

endmodule

// ===== rtl/core/fut_queue.sv =====
module fut_queue #(
  parameter int unsigned Depth = fut_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fut_pkg::desc_t  push_desc_i,
  output logic            space_o,
  input  logic            pop_i,
  output fut_pkg::head_t  head_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);

  fut_pkg::desc_t mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign space_o = (count_q != CountWidth'(Depth));
  assign do_push = push_i && space_o;
  assign do_pop = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.desc = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/core/fut_back.sv =====
module fut_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fut_pkg::head_t  head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fut_pkg::entry_t out_entry_o,
  output logic            out_last_o
);

  logic [fut_pkg::IdxWidth-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  fut_pkg::entry_t out_entry_q;
  logic            out_last_q;
  logic            load;
  logic            is_last;
  fut_pkg::entry_t sel;

  assign sel = head_i.desc.ent[idx_q];
  assign is_last = (fut_pkg::CntWidth'(idx_q) + 1'b1) == head_i.desc.cnt;
  assign load = head_i.valid && (!out_valid_q || out_ready_i);
  assign pop_o = load && is_last;

  always_comb begin
    idx_d = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d = is_last ? '0 : idx_q + 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_entry_q <= sel;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_entry_o = out_entry_q;
  assign out_last_o = out_last_q;

endmodule

// ===== rtl/core/form_urlencoded_tokenizer_unit.sv =====
// Channel   Direction  tdata            tlast             tuser
// s_axis    in         [7:0] in_byte    is_final          none
// m_axis    out        [7:0] out_byte   last_of_run       [2:0] kind
//
// Each accepted byte is classified combinationally and its results, if any, are queued as one entry.
// The first result of a byte is written into the queue and then into the output register before it reaches the output.
// The back end sends one result per cycle while the output is not stalled, so plain bytes stream at one per cycle.
// A delimiter or final byte with n results sends them one by one from its queue entry.
// Input stalls only when the result queue is full; output stalls never lose results.
// Reset clears the parser state, the queue pointers and the output valid flag at once.
module form_urlencoded_tokenizer_unit #(
  parameter int unsigned QueueDepth = fut_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser_o,   // [2:0] kind
  output logic        m_axis_tlast_o
);

  logic            space;
  logic            push;
  logic            pop;
  fut_pkg::desc_t  push_desc;
  fut_pkg::head_t  head;
  fut_pkg::entry_t out_entry;

  fut_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_byte_i   (s_axis_tdata_i),
    .is_final_i  (s_axis_tlast_i),
    .space_i     (space),
    .in_ready_o  (s_axis_tready_o),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  fut_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .space_o     (space),
    .pop_i       (pop),
    .head_o      (head)
  );

  fut_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_entry_o (out_entry),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = out_entry.data;
  assign m_axis_tuser_o = out_entry.kind;

endmodule

// ===== rtl/core/fut_checker.sv =====
module fut_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // A result that is not taken stays on the bus unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("output transaction changed while stalled");

  // Only the five defined kinds appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= 3'(fut_pkg::KIND_END_DATA))
    else $error("undefined result kind");

  // Markers carry a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != 3'(fut_pkg::KIND_NAME_BYTE) &&
      m_axis_tuser_o != 3'(fut_pkg::KIND_VALUE_BYTE) |->
      m_axis_tdata_o == '0)
    else $error("marker with nonzero data");

  // End of data always closes the run of its input byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == 3'(fut_pkg::KIND_END_DATA) |->
      m_axis_tlast_o)
    else $error("end of data without last flag");

  // Right after reset the input side is ready.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> s_axis_tready_o)
    else $error("input not ready after reset");

endmodule

bind form_urlencoded_tokenizer_unit fut_checker u_fut_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
